/* rtl/core/mpq_pkg.sv */
// mpq_pkg: shared types and constants of the min priority set
// used by mpq_cell and min_priority_set_decrease_key_top
package mpq_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CELL_W  = 64;
  localparam int unsigned BIT_W   = 6;
  localparam int unsigned ROW_W   = KEY_W - BIT_W;
  localparam int unsigned KEY_CAP = 1 << KEY_W;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic             set_en;
    logic [KEY_W-1:0] set_key;
    logic             clr_en;
    logic [KEY_W-1:0] clr_key;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
  } cell_cmd_t;

  typedef struct packed {
    logic hit_a;
    logic hit_b;
  } cell_rsp_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
  } link_t;

endpackage

/* rtl/core/mpq_cell.sv */
// mpq_cell: one row of presence bits with lookup, update and a registered
// lowest-key link to the next cell; depends on mpq_pkg
module mpq_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpq_pkg::cell_cmd_t cmd_i,
  input  mpq_pkg::link_t    link_i,
  output mpq_pkg::link_t    link_o,
  output mpq_pkg::cell_rsp_t rsp_o
);
  import mpq_pkg::*;

  localparam logic [ROW_W-1:0] ROW = ROW_W'(CELL_IDX);

  logic [CELL_W-1:0] word_q, word_d;
  link_t             link_q, link_d;
  logic [BIT_W-1:0]  pos;
  logic              any;

  always_comb begin
    word_d = word_q;
    if (cmd_i.clr_en && cmd_i.clr_key[KEY_W-1:BIT_W] == ROW) begin
      word_d[cmd_i.clr_key[BIT_W-1:0]] = 1'b0;
    end
    if (cmd_i.set_en && cmd_i.set_key[KEY_W-1:BIT_W] == ROW) begin
      word_d[cmd_i.set_key[BIT_W-1:0]] = 1'b1;
    end
  end

  assign rsp_o.hit_a = (cmd_i.key_a[KEY_W-1:BIT_W] == ROW) && word_q[cmd_i.key_a[BIT_W-1:0]];
  assign rsp_o.hit_b = (cmd_i.key_b[KEY_W-1:BIT_W] == ROW) && word_q[cmd_i.key_b[BIT_W-1:0]];

  // lowest set bit of this row
  always_comb begin
    pos = '0;
    any = |word_q;
    for (int i = CELL_W - 1; i >= 0; i--) begin
      if (word_q[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  always_comb begin
    if (link_i.found) begin
      link_d = link_i;
    end else begin
      link_d.found = any;
      link_d.key   = {ROW, pos};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      link_q <= '0;
    end else begin
      word_q <= word_d;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

/* rtl/core/min_priority_set_decrease_key_top.sv */
// min_priority_set_decrease_key_top: priority set of distinct keys with
// insert, extract minimum and decrease key; depends on mpq_pkg, mpq_cell
//
// Usage: drive operation_i, item_key_i and decrement_i and raise start_i;
// the command is taken at a rising edge where start_i is high and busy_o
// is low. Exactly one result follows per transaction: done_o is high for
// one cycle with status_o, min_value_o and held_count_o valid in that
// cycle. The receiver cannot stall; the result must be taken when shown.
// Insert, decrease key and failing commands finish in ST_EVAL, which is
// entered at the accepting edge; done_o is registered from there. Extract
// minimum waits until the lowest-key search has run through the row of cells
// since the last change of the store. Transactions do not overlap; a new
// command can be taken in the cycle its result is shown.
// The search wave moves one cell per cycle along the chain and sets how long
// extract minimum waits. Reset clears all presence bits and the count at
// once; the block is ready as soon as reset is released.
module min_priority_set_decrease_key_top #(
  parameter int unsigned KEY_RANGE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  item_key_i,
  input  logic [9:0]  decrement_i,
  output logic        done_o,
  output logic        status_o,
  output logic [9:0]  min_value_o,
  output logic [10:0] held_count_o
);
  import mpq_pkg::*;

  localparam int unsigned STORE_BITS = (KEY_RANGE < KEY_CAP) ? KEY_RANGE : KEY_CAP;
  localparam int unsigned NUM_CELLS  = (STORE_BITS + CELL_W - 1) / CELL_W;
  localparam int unsigned SET_W      = $clog2(NUM_CELLS + 1);
  localparam logic [16:0] KEY_LIMIT  = 17'(KEY_RANGE);

  state_e           state_q, state_d;
  op_e              op_q;
  logic [KEY_W-1:0] key_q, dec_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SET_W-1:0] settle_q, settle_d;
  logic             done_q, status_q;
  logic [KEY_W-1:0] min_q;

  cell_cmd_t        cmd;
  cell_rsp_t        rsp [NUM_CELLS];
  link_t            chain [NUM_CELLS+1];
  logic             hit_a, hit_b;
  logic [KEY_W-1:0] new_key;
  logic             dec_ok, in_range;
  logic             fin, fin_status;
  logic [KEY_W-1:0] fin_min;
  logic             accept;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign new_key  = key_q - dec_q;
  assign dec_ok   = dec_q <= key_q;
  assign in_range = {7'b0, key_q} < KEY_LIMIT;
  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mpq_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .link_i(chain[g]),
      .link_o(chain[g+1]),
      .rsp_o (rsp[g])
    );
  end

  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      hit_a = hit_a | rsp[i].hit_a;
      hit_b = hit_b | rsp[i].hit_b;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (fin) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command evaluation and store update
  always_comb begin
    cmd         = '0;
    cmd.key_a   = key_q;
    cmd.key_b   = new_key;
    cnt_d       = cnt_q;
    fin         = 1'b0;
    fin_status  = 1'b1;
    fin_min     = '0;
    if (state_q == ST_EVAL) begin
      case (op_q)
        OP_INSERT: begin
          fin = 1'b1;
          if (in_range && !hit_a) begin
            cmd.set_en  = 1'b1;
            cmd.set_key = key_q;
            cnt_d       = cnt_q + 11'd1;
            fin_status  = 1'b0;
          end
        end
        OP_EXTRACT: begin
          if (cnt_q == '0) begin
            fin = 1'b1;
          end else if (settle_q == '0) begin
            fin         = 1'b1;
            cmd.clr_en  = 1'b1;
            cmd.clr_key = chain[NUM_CELLS].key;
            cnt_d       = cnt_q - 11'd1;
            fin_status  = 1'b0;
            fin_min     = chain[NUM_CELLS].key;
          end
        end
        OP_DECREASE: begin
          fin = 1'b1;
          if (in_range && hit_a && dec_ok) begin
            if (dec_q == '0) begin
              fin_status = 1'b0;
            end else if (!hit_b) begin
              cmd.clr_en  = 1'b1;
              cmd.clr_key = key_q;
              cmd.set_en  = 1'b1;
              cmd.set_key = new_key;
              fin_status  = 1'b0;
            end
          end
        end
        default: fin = 1'b1;
      endcase
    end
  end

  // counts down while the search chain settles after a store change
  always_comb begin
    if (cmd.set_en || cmd.clr_en) begin
      settle_d = SET_W'(NUM_CELLS);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end else begin
      settle_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      settle_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      settle_q <= settle_d;
      done_q   <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      key_q <= item_key_i;
      dec_q <= decrement_i;
    end
    status_q <= fin_status;
    min_q    <= fin_min;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign min_value_o  = min_q;
  assign held_count_o = cnt_q;

  a_done_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EVAL))
    else $error("result without evaluation");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STORE_BITS))
    else $error("held count above store size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + 11'd1 || cnt_q == $past(cnt_q) - 11'd1))
    else $error("held count jumped");

  a_error_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (min_value_o == '0))
    else $error("failed transaction reports a key");

  a_extract_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && op_q == OP_EXTRACT && fin && !fin_status)
      |-> (settle_q == '0 && chain[NUM_CELLS].found))
    else $error("extract used an unsettled search");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for min_priority_set_decrease_key_top, directed table then random
// transactions checked against a key-set predictor; depends on mpq_pkg and the rtl
module tb;
  import mpq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ERR = 1'b1;
  localparam int NUM_KEYS = 1024;
  localparam int NUM_ROWS = 24;
  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        status;
    logic [9:0]  min_value;
    logic [10:0] held_count;
  } outcome_t;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] key;
    logic [9:0] dec;
    logic       given;
    outcome_t   res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  operation_i = '0;
  logic [9:0]  item_key_i = '0;
  logic [9:0]  decrement_i = '0;
  logic        done_o;
  logic        status_o;
  logic [9:0]  min_value_o;
  logic [10:0] held_count_o;

  // typed expectation of the transaction on the ports, moves with the inputs
  logic     row_given = 1'b0;
  outcome_t row_result = '0;

  bit       key_present [NUM_KEYS];
  int       keys_held;
  outcome_t pending_outcomes [$];

  int mismatches;
  int results_seen;
  int accepted;
  int op_seen [4];
  int errors_seen;
  int peak_held;
  int stall_cycles;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{OP_EXTRACT,  10'd0,    10'd0,    1'b1, '{STATUS_ERR, 10'd0,   11'd0}},
    '{OP_DECREASE, 10'd0,    10'd0,    1'b1, '{STATUS_ERR, 10'd0,   11'd0}},
    '{OP_INSERT,   10'd1023, 10'd0,    1'b1, '{STATUS_OK,  10'd0,   11'd1}},
    '{OP_INSERT,   10'd0,    10'd1023, 1'b1, '{STATUS_OK,  10'd0,   11'd2}},
    '{OP_INSERT,   10'd0,    10'd0,    1'b1, '{STATUS_ERR, 10'd0,   11'd2}},
    '{OP_INSERT,   10'd1023, 10'd0,    1'b1, '{STATUS_ERR, 10'd0,   11'd2}},
    '{OP_DECREASE, 10'd1023, 10'd1023, 1'b1, '{STATUS_ERR, 10'd0,   11'd2}},
    '{OP_DECREASE, 10'd0,    10'd1,    1'b1, '{STATUS_ERR, 10'd0,   11'd2}},
    '{OP_DECREASE, 10'd1023, 10'd0,    1'b1, '{STATUS_OK,  10'd0,   11'd2}},
    '{OP_UNUSED,   10'd1023, 10'd1023, 1'b1, '{STATUS_ERR, 10'd0,   11'd2}},
    '{OP_EXTRACT,  10'd1023, 10'd1023, 1'b1, '{STATUS_OK,  10'd0,   11'd1}},
    '{OP_DECREASE, 10'd1023, 10'd1023, 1'b1, '{STATUS_OK,  10'd0,   11'd1}},
    '{OP_INSERT,   10'd682,  10'd0,    1'b1, '{STATUS_OK,  10'd0,   11'd2}},
    '{OP_INSERT,   10'd341,  10'd0,    1'b1, '{STATUS_OK,  10'd0,   11'd3}},
    '{OP_DECREASE, 10'd682,  10'd341,  1'b1, '{STATUS_ERR, 10'd0,   11'd3}},
    '{OP_DECREASE, 10'd682,  10'd681,  1'b1, '{STATUS_OK,  10'd0,   11'd3}},
    '{OP_DECREASE, 10'd341,  10'd342,  1'b1, '{STATUS_ERR, 10'd0,   11'd3}},
    '{OP_EXTRACT,  10'd0,    10'd0,    1'b1, '{STATUS_OK,  10'd0,   11'd2}},
    '{OP_EXTRACT,  10'd0,    10'd0,    1'b1, '{STATUS_OK,  10'd1,   11'd1}},
    '{OP_EXTRACT,  10'd0,    10'd0,    1'b1, '{STATUS_OK,  10'd341, 11'd0}},
    '{OP_EXTRACT,  10'd0,    10'd0,    1'b1, '{STATUS_ERR, 10'd0,   11'd0}},
    '{OP_INSERT,   10'd512,  10'd0,    1'b0, '0},
    '{OP_DECREASE, 10'd512,  10'd512,  1'b0, '0},
    '{OP_EXTRACT,  10'd0,    10'd0,    1'b0, '0}
  };

  min_priority_set_decrease_key_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .item_key_i  (item_key_i),
    .decrement_i (decrement_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .min_value_o (min_value_o),
    .held_count_o(held_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // applies one command to the key set and returns the outcome it gives
  function automatic outcome_t apply_to_key_set(input logic [1:0] op, input logic [9:0] key,
                                                input logic [9:0] dec);
    outcome_t res;
    int target;
    res = '{STATUS_ERR, 10'd0, 11'd0};
    case (op)
      OP_INSERT: begin
        if (!key_present[key]) begin
          key_present[key] = 1'b1;
          keys_held++;
          res.status = STATUS_OK;
        end
      end
      OP_EXTRACT: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (key_present[k]) begin
            key_present[k] = 1'b0;
            keys_held--;
            res.min_value = k[9:0];
            res.status = STATUS_OK;
            break;
          end
        end
      end
      OP_DECREASE: begin
        if (key_present[key] && dec <= key) begin
          target = int'(key) - int'(dec);
          if (target == int'(key)) begin
            res.status = STATUS_OK;
          end else if (!key_present[target]) begin
            key_present[key] = 1'b0;
            key_present[target] = 1'b1;
            res.status = STATUS_OK;
          end
        end
      end
      default: ;
    endcase
    res.held_count = keys_held[10:0];
    return res;
  endfunction

  // nearest held key at or above a random start, wrapping; random key if none
  function automatic logic [9:0] pick_held_key(input int from);
    for (int j = 0; j < NUM_KEYS; j++) begin
      if (key_present[(from + j) % NUM_KEYS]) return 10'((from + j) % NUM_KEYS);
    end
    return 10'(from);
  endfunction

  task automatic issue(input logic [1:0] op, input logic [9:0] key, input logic [9:0] dec,
                       input logic given, input outcome_t res, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    item_key_i  <= key;
    decrement_i <= dec;
    row_given   <= given;
    row_result  <= res;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // predicts on every accepted transaction, checks every result strobe
  always @(posedge clk_i) begin
    outcome_t predicted;
    outcome_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predicted = apply_to_key_set(operation_i, item_key_i, decrement_i);
        pending_outcomes.push_back(row_given ? row_result : predicted);
        accepted++;
        op_seen[operation_i]++;
        if (keys_held > peak_held) peak_held = keys_held;
      end
      if (done_o) begin
        results_seen++;
        if (status_o == STATUS_ERR) errors_seen++;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result with nothing expected: status %0d min %0d count %0d",
                     status_o, min_value_o, held_count_o);
        end else begin
          want = pending_outcomes.pop_front();
          if (status_o !== want.status || min_value_o !== want.min_value ||
              held_count_o !== want.held_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected status %0d min %0d count %0d, got %0d %0d %0d",
                       results_seen, want.status, want.min_value, want.held_count,
                       status_o, min_value_o, held_count_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results pending",
               stall_cycles, pending_outcomes.size());
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int idle_pct;
    int per_phase;
    int roll;
    int mode;
    logic [1:0] op;
    logic [9:0] key;
    logic [9:0] dec;
    keys_held = 0;
    mismatches = 0;
    results_seen = 0;
    accepted = 0;
    errors_seen = 0;
    peak_held = 0;
    stall_cycles = 0;
    op_seen = '{0, 0, 0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue(directed_rows[i].op, directed_rows[i].key, directed_rows[i].dec,
            directed_rows[i].given, directed_rows[i].res, 8);

    per_phase = RANDOM_ITEMS / 3;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 88 : 0;
      for (int n = 0; n < per_phase; n++) begin
        // fill early in each phase, drain later
        roll = $urandom_range(99);
        if (roll < 2) op = OP_UNUSED;
        else if (roll < ((n < per_phase / 3) ? 62 : 34)) op = OP_INSERT;
        else if (roll < ((n < per_phase / 3) ? 80 : 68)) op = OP_EXTRACT;
        else op = OP_DECREASE;

        mode = $urandom_range(3);
        case (mode)
          0: key = 10'($urandom_range(1023));
          1: key = 10'($urandom_range(31));
          2: key = 10'(1023 - $urandom_range(31));
          default: key = pick_held_key(int'($urandom_range(1023)));
        endcase
        if (op == OP_DECREASE && $urandom_range(1) == 1) key = pick_held_key(int'(key));

        mode = $urandom_range(5);
        case (mode)
          0: dec = 10'd0;
          1: dec = key;
          2: dec = (key == 10'd1023) ? 10'd1023 : key + 10'd1;
          3: dec = 10'($urandom_range(1023));
          default: dec = 10'($urandom_range(int'(key)));
        endcase
        issue(op, key, dec, 1'b0, '0, idle_pct);
      end
    end
    start_i <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transactions (insert %0d, extract %0d, decrease %0d, unused %0d)",
             accepted, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d results, %0d with error status, up to %0d keys held, %0d mismatches",
             results_seen, errors_seen, peak_held, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* min_priority_set_decrease_key_top.f */
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_set_decrease_key_top.sv
bench/tb.sv
